// ----- hw/rtl/l1_victim_l2_cache_lookup_defines.svh -----
// ----------------------------------------------------------------------------
// l1_victim_l2_cache_lookup_defines
// Assertion macros used by the cache lookup.
// ----------------------------------------------------------------------------
`ifndef L1_VICTIM_L2_CACHE_LOOKUP_DEFINES_SVH
`define L1_VICTIM_L2_CACHE_LOOKUP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define LVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define LVC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/lvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lvc_pkg
// Shared geometry, register indexes and level codes of the cache lookup.
// ----------------------------------------------------------------------------
`default_nettype none
package lvc_pkg;
	localparam int L1_SETS        = 128;
	localparam int VICTIM_SETS    = 16;
	localparam int L2_SETS        = 4096;
	localparam int WAYS           = 2;
	localparam int L1_BLOCK_BYTES = 16;
	localparam int L2_BLOCK_BYTES = 32;

	localparam int L1_OFF  = $clog2(L1_BLOCK_BYTES);
	localparam int L2_OFF  = $clog2(L2_BLOCK_BYTES);
	localparam int L1_IW   = $clog2(L1_SETS);
	localparam int VC_IW   = $clog2(VICTIM_SETS);
	localparam int L2_IW   = $clog2(L2_SETS);
	localparam int L1_TW   = 32 - L1_OFF - L1_IW;
	localparam int VC_TW   = 32 - L1_OFF - VC_IW;
	localparam int L2_TW   = 32 - L2_OFF - L2_IW;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam int          REG_CNT  = 5;
	localparam logic [2:0]  REG_L1   = 3'd0;
	localparam logic [2:0]  REG_VC   = 3'd1;
	localparam logic [2:0]  REG_L2   = 3'd2;
	localparam logic [2:0]  REG_XFER = 3'd3;
	localparam logic [2:0]  REG_MEM  = 3'd4;

	localparam logic [1:0] LVL_L1  = 2'd0;
	localparam logic [1:0] LVL_VC  = 2'd1;
	localparam logic [1:0] LVL_L2  = 2'd2;
	localparam logic [1:0] LVL_MEM = 2'd3;

	typedef logic [1:0]  level_t;
	typedef logic [16:0] lat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/l1_victim_l2_cache_lookup.sv -----
// ----------------------------------------------------------------------------
// l1_victim_l2_cache_lookup
// Tag-only L1 / victim / L2 lookup with stamp-based LRU replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result appears
// for exactly one cycle with done high, and the receiver cannot stall it.
// Each request walks a small sequencer over one shared tag/stamp compare
// unit, one way per cycle; the tag memories have registered reads. Every
// request scans the L1 set and then the L2 set; on an L1 miss the victim
// set is scanned between them and the block is written into L1, and when
// that fill pushes a valid block out, a victim set is scanned for its slot.
// The result comes in the same cycle that busy drops, and a new request can
// be taken in that same cycle. After reset all L2_SETS*WAYS (8192) L2 valid
// bits are swept clear, one entry per cycle, while busy stays high.
`default_nettype none
`include "l1_victim_l2_cache_lookup_defines.svh"
module l1_victim_l2_cache_lookup (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                is_store,
	input  wire logic [31:0]         mem_address,
	input  wire logic [31:0]         time_stamp,
	output logic                     done,
	output lvc_pkg::level_t          hit_level,
	output lvc_pkg::lat_t            access_latency
);
	import lvc_pkg::*;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_L1   = 3'd2;  // scan L1 ways
	localparam logic [2:0] ST_VC   = 3'd3;  // scan victim ways
	localparam logic [2:0] ST_L2   = 3'd4;  // scan L2 ways
	localparam logic [2:0] ST_L1F  = 3'd5;  // write L1 fill
	localparam logic [2:0] ST_VCS  = 3'd6;  // scan victim for fill slot
	localparam logic [2:0] ST_DONE = 3'd7;

	localparam int L1_AW = L1_IW + WAY_W;
	localparam int VC_AW = VC_IW + WAY_W;
	localparam int L2_AW = L2_IW + WAY_W;
	localparam int L1_D  = 1 << L1_AW;
	localparam int VC_D  = 1 << VC_AW;
	localparam int L2_D  = 1 << L2_AW;

	// Tag and stamp memories
	logic [L1_TW-1:0] l1_tag_mem [L1_D];
	logic [31:0]      l1_stp_mem [L1_D];
	logic [L1_D-1:0]  l1_vld_q;
	logic [VC_TW-1:0] vc_tag_mem [VC_D];
	logic [31:0]      vc_stp_mem [VC_D];
	logic [VC_D-1:0]  vc_vld_q;
	logic [L2_TW-1:0] l2_tag_mem [L2_D];
	logic [31:0]      l2_stp_mem [L2_D];
	logic             l2_vld_mem [L2_D];

	logic [15:0] regs_q [REG_CNT];
	logic [2:0]  state_q;
	logic [31:0] addr_q, now_q;
	level_t      level_q;
	logic        done_q;
	lat_t        lat_q;
	logic [L2_AW-1:0] clr_q;

	// Scan bookkeeping shared by all levels
	logic [WAY_W-1:0] way_q;       // next way to read
	logic             iss_done_q;  // all ways of the set have been read
	logic [WAY_W-1:0] rd_way_q;    // way of the read data
	logic             rd_ok_q;     // read data belongs to this scan
	logic             hit_q;
	logic [WAY_W-1:0] hway_q;
	logic             inv_q;
	logic [WAY_W-1:0] pick_q;
	logic [31:0]      min_q;
	logic             refresh_only_q;

	// L1 fill choice, kept from the L1 scan
	logic [WAY_W-1:0] l1_pick_q;
	logic             l1_evict_q;
	logic [L1_TW-1:0] ev_tag_q;
	logic [31:0]      ev_stp_q;

	// Registered read data
	logic [L1_TW-1:0] l1_tag_rd;
	logic [31:0]      l1_stp_rd;
	logic [VC_TW-1:0] vc_tag_rd;
	logic [31:0]      vc_stp_rd;
	logic [L2_TW-1:0] l2_tag_rd;
	logic [31:0]      l2_stp_rd;
	logic             l2_vld_rd;

	wire [L1_IW-1:0] i1 = addr_q[L1_OFF +: L1_IW];
	wire [L1_TW-1:0] t1 = addr_q[31 -: L1_TW];
	wire [VC_IW-1:0] iv = addr_q[L1_OFF +: VC_IW];
	wire [VC_TW-1:0] tv = addr_q[31 -: VC_TW];
	wire [L2_IW-1:0] i2 = addr_q[L2_OFF +: L2_IW];
	wire [L2_TW-1:0] t2 = addr_q[31 -: L2_TW];

	// Victim address of the evicted L1 block
	logic [31:0]      ev_addr;
	wire [VC_IW-1:0]  ev_iv = ev_addr[L1_OFF +: VC_IW];
	wire [VC_TW-1:0]  ev_tv = ev_addr[31 -: VC_TW];
	assign ev_addr = {ev_tag_q, i1, {L1_OFF{1'b0}}};

	// Read one way per level each cycle
	logic [VC_IW-1:0] vc_set;
	logic [L1_AW-1:0] l1_ra;
	logic [VC_AW-1:0] vc_ra;
	logic [L2_AW-1:0] l2_ra;
	assign vc_set = (state_q == ST_VCS) ? ev_iv : iv;
	assign l1_ra  = {i1, way_q};
	assign vc_ra  = {vc_set, way_q};
	assign l2_ra  = {i2, way_q};

	always_ff @(posedge clk) begin
		l1_tag_rd <= l1_tag_mem[l1_ra];
		l1_stp_rd <= l1_stp_mem[l1_ra];
		vc_tag_rd <= vc_tag_mem[vc_ra];
		vc_stp_rd <= vc_stp_mem[vc_ra];
		l2_tag_rd <= l2_tag_mem[l2_ra];
		l2_stp_rd <= l2_stp_mem[l2_ra];
		l2_vld_rd <= l2_vld_mem[l2_ra];
	end

	// Shared compare unit: selects the read way's fields by level
	logic             cu_vld;
	logic             cu_match;
	logic [31:0]      cu_stp;
	always_comb begin
		cu_vld   = 1'b0;
		cu_match = 1'b0;
		cu_stp   = '0;
		unique case (state_q)
			ST_L1: begin
				cu_vld   = l1_vld_q[{i1, rd_way_q}];
				cu_match = (l1_tag_rd == t1);
				cu_stp   = l1_stp_rd;
			end
			ST_VC, ST_VCS: begin
				cu_vld   = vc_vld_q[{vc_set, rd_way_q}];
				cu_match = (vc_tag_rd == tv);
				cu_stp   = vc_stp_rd;
			end
			ST_L2: begin
				cu_vld   = l2_vld_rd;
				cu_match = (l2_tag_rd == t2);
				cu_stp   = l2_stp_rd;
			end
			default: ;
		endcase
	end

	// Track first hit, first invalid way and oldest way, lowest way on a tie
	logic             scan_last;
	logic             hit_nx;
	logic [WAY_W-1:0] hway_nx;
	logic             inv_nx;
	logic [WAY_W-1:0] pick_nx;
	logic [31:0]      min_nx;
	logic [L1_TW-1:0] ev_tag_nx;
	logic [31:0]      ev_stp_nx;
	assign scan_last = rd_ok_q && (rd_way_q == WAY_W'(WAYS - 1));
	always_comb begin
		hit_nx    = hit_q;
		hway_nx   = hway_q;
		inv_nx    = inv_q;
		pick_nx   = pick_q;
		min_nx    = min_q;
		ev_tag_nx = ev_tag_q;
		ev_stp_nx = ev_stp_q;
		if (rd_ok_q) begin
			if (cu_vld && cu_match && !hit_q) begin
				hit_nx  = 1'b1;
				hway_nx = rd_way_q;
			end
			if (!inv_q) begin
				if (!cu_vld) begin
					inv_nx  = 1'b1;
					pick_nx = rd_way_q;
				end else if (rd_way_q == '0 || cu_stp < min_q) begin
					pick_nx   = rd_way_q;
					min_nx    = cu_stp;
					ev_tag_nx = l1_tag_rd;
					ev_stp_nx = cu_stp;
				end
			end
		end
	end

	// Write ports of the memories
	logic             l1_stp_we;
	logic [L1_AW-1:0] l1_wa;
	logic             vc_stp_we;
	logic             vc_fill;
	logic [VC_AW-1:0] vc_wa;
	logic [31:0]      vc_wstp;
	logic             l2_stp_we;
	logic             l2_fill;
	logic [L2_AW-1:0] l2_wa;
	assign l1_stp_we = (state_q == ST_L1 && scan_last && hit_nx) || state_q == ST_L1F;
	assign l1_wa     = (state_q == ST_L1F) ? {i1, l1_pick_q} : {i1, hway_nx};
	assign vc_fill   = scan_last && state_q == ST_VCS;
	assign vc_stp_we = (scan_last && state_q == ST_VC && hit_nx) || vc_fill;
	assign vc_wa     = {vc_set, vc_fill ? pick_nx : hway_nx};
	assign vc_wstp   = vc_fill ? ev_stp_q : now_q;
	assign l2_stp_we = scan_last && state_q == ST_L2 && (hit_nx || !refresh_only_q);
	assign l2_fill   = scan_last && state_q == ST_L2 && !hit_nx && !refresh_only_q;
	assign l2_wa     = {i2, hit_nx ? hway_nx : pick_nx};

	always_ff @(posedge clk) begin
		if (l1_stp_we)
			l1_stp_mem[l1_wa] <= now_q;
		if (state_q == ST_L1F)
			l1_tag_mem[l1_wa] <= t1;
		if (vc_stp_we)
			vc_stp_mem[vc_wa] <= vc_wstp;
		if (vc_fill)
			vc_tag_mem[vc_wa] <= ev_tv;
		if (l2_stp_we)
			l2_stp_mem[l2_wa] <= now_q;
		if (l2_fill)
			l2_tag_mem[l2_wa] <= t2;
		if (state_q == ST_CLR)
			l2_vld_mem[clr_q] <= 1'b0;
		else if (l2_fill)
			l2_vld_mem[l2_wa] <= 1'b1;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			clr_q          <= '0;
			way_q          <= '0;
			iss_done_q     <= 1'b0;
			rd_way_q       <= '0;
			rd_ok_q        <= 1'b0;
			done_q         <= 1'b0;
			level_q        <= LVL_L1;
			lat_q          <= '0;
			l1_vld_q       <= '0;
			vc_vld_q       <= '0;
			hit_q          <= 1'b0;
			hway_q         <= '0;
			inv_q          <= 1'b0;
			pick_q         <= '0;
			min_q          <= '0;
			l1_pick_q      <= '0;
			l1_evict_q     <= 1'b0;
			ev_tag_q       <= '0;
			ev_stp_q       <= '0;
			refresh_only_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == L2_AW'(L2_D - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						state_q        <= ST_L1;
						refresh_only_q <= 1'b0;
					end
				end
				ST_L1, ST_VC, ST_L2, ST_VCS: begin
					if (scan_last) begin
						// Close the scan and pick the next step
						way_q      <= '0;
						iss_done_q <= 1'b0;
						rd_ok_q    <= 1'b0;
						hit_q      <= 1'b0;
						inv_q      <= 1'b0;
						unique case (state_q)
							ST_L1: begin
								if (hit_nx) begin
									level_q        <= LVL_L1;
									lat_q          <= lat_t'(regs_q[REG_L1]);
									refresh_only_q <= 1'b1;
									state_q        <= ST_L2;
								end else begin
									l1_pick_q  <= pick_nx;
									l1_evict_q <= !inv_nx;
									ev_tag_q   <= ev_tag_nx;
									ev_stp_q   <= ev_stp_nx;
									state_q    <= ST_VC;
								end
							end
							ST_VC: begin
								if (hit_nx) begin
									level_q        <= LVL_VC;
									lat_q          <= lat_t'(regs_q[REG_VC]);
									refresh_only_q <= 1'b1;
								end
								state_q <= ST_L2;
							end
							ST_L2: begin
								if (refresh_only_q) begin
									state_q <= (level_q == LVL_L1) ? ST_DONE : ST_L1F;
								end else begin
									if (hit_nx) begin
										level_q <= LVL_L2;
										lat_q   <= lat_t'(regs_q[REG_XFER])
											+ lat_t'(regs_q[REG_L2]);
									end else begin
										level_q <= LVL_MEM;
										lat_q   <= lat_t'(regs_q[REG_MEM]);
									end
									state_q <= ST_L1F;
								end
							end
							default: begin  // victim slot chosen
								vc_vld_q[{ev_iv, pick_nx}] <= 1'b1;
								state_q <= ST_DONE;
							end
						endcase
					end else begin
						// Advance the read way and fold in the read data
						rd_way_q <= way_q;
						rd_ok_q  <= !iss_done_q;
						if (way_q == WAY_W'(WAYS - 1))
							iss_done_q <= 1'b1;
						else
							way_q <= WAY_W'(way_q + 1'b1);
						hit_q  <= hit_nx;
						hway_q <= hway_nx;
						inv_q  <= inv_nx;
						pick_q <= pick_nx;
						min_q  <= min_nx;
						if (state_q == ST_L1) begin
							ev_tag_q <= ev_tag_nx;
							ev_stp_q <= ev_stp_nx;
						end
					end
				end
				ST_L1F: begin
					l1_vld_q[{i1, l1_pick_q}] <= 1'b1;
					state_q <= l1_evict_q ? ST_VCS : ST_DONE;
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			addr_q <= mem_address;
			now_q  <= time_stamp;
		end
	end

	// Configuration registers
	wire cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_L1]   <= 16'd1;
			regs_q[REG_VC]   <= 16'd2;
			regs_q[REG_L2]   <= 16'd10;
			regs_q[REG_XFER] <= 16'd4;
			regs_q[REG_MEM]  <= 16'd100;
		end else if (cfg_wr && paddr[4:2] < 3'(REG_CNT)) begin
			regs_q[paddr[4:2]] <= pwdata[15:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[4:2] < 3'(REG_CNT))
			prdata = {16'd0, regs_q[paddr[4:2]]};
	end

	assign pready         = 1'b1;
	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign hit_level      = level_q;
	assign access_latency = lat_q;

	wire unused_ok = is_store ^ paddr[0] ^ paddr[1] ^ (|pwdata[31:16]);

	`LVC_ASSERT_IMP(a_done_idle, clk, arst_n, done, state_q == ST_IDLE, "result outside idle")
	`LVC_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "request not taken")
	`LVC_ASSERT_IMP(a_done_one, clk, arst_n, done, !$past(done), "result held twice")
endmodule
`default_nettype wire

// ----- dv/l1_victim_l2_cache_lookup_checker.sv -----
// ----------------------------------------------------------------------------
// l1_victim_l2_cache_lookup_checker
// Watches the register port, the request channel and the result strobe of
// the cache lookup, keeps its own L1 / victim / L2 tag and stamp image, and
// compares each result with the oldest predicted hit level and latency.
// ----------------------------------------------------------------------------
`default_nettype none
module l1_victim_l2_cache_lookup_checker
	import lvc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [31:0] mem_address,
	input  wire logic [31:0] time_stamp,
	input  wire logic        done,
	input  wire level_t      hit_level,
	input  wire lat_t        access_latency,
	output int               fail_count,
	output int               pending_count
);
	// Latency registers as the block should hold them
	logic [15:0] lat_l1, lat_vc, lat_l2, lat_xfer, lat_mem;

	// Tag image of the three levels
	logic [WAYS-1:0][L1_TW-1:0] l1_tag   [L1_SETS];
	logic [WAYS-1:0][31:0]      l1_stamp [L1_SETS];
	logic [WAYS-1:0]            l1_vld   [L1_SETS];
	logic [WAYS-1:0][VC_TW-1:0] vc_tag   [VICTIM_SETS];
	logic [WAYS-1:0][31:0]      vc_stamp [VICTIM_SETS];
	logic [WAYS-1:0]            vc_vld   [VICTIM_SETS];
	logic [WAYS-1:0][L2_TW-1:0] l2_tag   [L2_SETS];
	logic [WAYS-1:0][31:0]      l2_stamp [L2_SETS];
	logic [WAYS-1:0]            l2_vld   [L2_SETS];

	level_t level_q [$];
	lat_t   lat_q   [$];

	assign pending_count = level_q.size();

	// First invalid way, else the oldest stamp; lowest way wins a tie
	function automatic int pick_victim_way(input logic [WAYS-1:0] vld,
			input logic [WAYS-1:0][31:0] stamps, output logic evicts);
		int pick;
		pick = 0;
		evicts = 1'b1;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!vld[w]) begin
				pick = w;
				evicts = 1'b0;
			end
		end
		if (evicts) begin
			for (int w = 1; w < WAYS; w++) begin
				if (stamps[w] < stamps[pick])
					pick = w;
			end
		end
		return pick;
	endfunction

	// Fill L1 and push any displaced valid block into the victim cache
	task automatic fill_l1(input logic [31:0] addr, input logic [31:0] now);
		logic [L1_IW-1:0] idx;
		logic [31:0]      ev_addr;
		logic [31:0]      ev_stamp;
		logic             evicts, dummy;
		int               w, vw;
		logic [VC_IW-1:0] vidx;
		idx = addr[L1_OFF +: L1_IW];
		w = pick_victim_way(l1_vld[idx], l1_stamp[idx], evicts);
		ev_addr = {l1_tag[idx][w], idx, {L1_OFF{1'b0}}};
		ev_stamp = l1_stamp[idx][w];
		l1_vld[idx][w] = 1'b1;
		l1_tag[idx][w] = addr[31 -: L1_TW];
		l1_stamp[idx][w] = now;
		if (evicts) begin
			vidx = ev_addr[L1_OFF +: VC_IW];
			vw = pick_victim_way(vc_vld[vidx], vc_stamp[vidx], dummy);
			vc_vld[vidx][vw] = 1'b1;
			vc_tag[vidx][vw] = ev_addr[31 -: VC_TW];
			vc_stamp[vidx][vw] = ev_stamp;
		end
	endtask

	// Refresh the first matching valid L2 way, if any
	task automatic refresh_l2(input logic [31:0] addr, input logic [31:0] now);
		logic [L2_IW-1:0] idx;
		idx = addr[L2_OFF +: L2_IW];
		for (int w = 0; w < WAYS; w++) begin
			if (l2_vld[idx][w] && l2_tag[idx][w] == addr[31 -: L2_TW]) begin
				l2_stamp[idx][w] = now;
				break;
			end
		end
	endtask

	// Walk the hierarchy for one request and queue its hit level and latency
	task automatic resolve_reference(input logic [31:0] addr, input logic [31:0] now);
		logic [L1_IW-1:0] i1;
		logic [VC_IW-1:0] iv;
		logic [L2_IW-1:0] i2;
		int               h1, hv, h2, w;
		logic             dummy;
		i1 = addr[L1_OFF +: L1_IW];
		iv = addr[L1_OFF +: VC_IW];
		i2 = addr[L2_OFF +: L2_IW];
		h1 = -1;
		hv = -1;
		h2 = -1;
		for (int k = WAYS - 1; k >= 0; k--) begin
			if (l1_vld[i1][k] && l1_tag[i1][k] == addr[31 -: L1_TW])
				h1 = k;
			if (vc_vld[iv][k] && vc_tag[iv][k] == addr[31 -: VC_TW])
				hv = k;
			if (l2_vld[i2][k] && l2_tag[i2][k] == addr[31 -: L2_TW])
				h2 = k;
		end
		if (h1 >= 0) begin
			l1_stamp[i1][h1] = now;
			refresh_l2(addr, now);
			level_q.push_back(LVL_L1);
			lat_q.push_back(lat_t'(lat_l1));
		end else if (hv >= 0) begin
			vc_stamp[iv][hv] = now;
			fill_l1(addr, now);
			refresh_l2(addr, now);
			level_q.push_back(LVL_VC);
			lat_q.push_back(lat_t'(lat_vc));
		end else if (h2 >= 0) begin
			l2_stamp[i2][h2] = now;
			fill_l1(addr, now);
			level_q.push_back(LVL_L2);
			lat_q.push_back(lat_t'(lat_l2) + lat_t'(lat_xfer));
		end else begin
			w = pick_victim_way(l2_vld[i2], l2_stamp[i2], dummy);
			l2_vld[i2][w] = 1'b1;
			l2_tag[i2][w] = addr[31 -: L2_TW];
			l2_stamp[i2][w] = now;
			fill_l1(addr, now);
			level_q.push_back(LVL_MEM);
			lat_q.push_back(lat_t'(lat_mem));
		end
	endtask

	// Track register writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_l1 <= 16'd1;
			lat_vc <= 16'd2;
			lat_l2 <= 16'd10;
			lat_xfer <= 16'd4;
			lat_mem <= 16'd100;
			for (int s = 0; s < L1_SETS; s++) l1_vld[s] = '0;
			for (int s = 0; s < VICTIM_SETS; s++) vc_vld[s] = '0;
			for (int s = 0; s < L2_SETS; s++) l2_vld[s] = '0;
			level_q.delete();
			lat_q.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_L1:   lat_l1 <= pwdata[15:0];
					REG_VC:   lat_vc <= pwdata[15:0];
					REG_L2:   lat_l2 <= pwdata[15:0];
					REG_XFER: lat_xfer <= pwdata[15:0];
					REG_MEM:  lat_mem <= pwdata[15:0];
					default: ;
				endcase
			end
			if (done) begin
				if (level_q.size() == 0) begin
					$error("result with no request outstanding: level %0d latency %0d",
						hit_level, access_latency);
					fail_count <= fail_count + 1;
				end else begin
					if (hit_level !== level_q[0]) begin
						$error("hit_level expected %0d actual %0d", level_q[0], hit_level);
						fail_count <= fail_count + 1;
					end else if (access_latency !== lat_q[0]) begin
						$error("access_latency expected %0d actual %0d",
							lat_q[0], access_latency);
						fail_count <= fail_count + 1;
					end
					void'(level_q.pop_front());
					void'(lat_q.pop_front());
				end
			end
			if (start && !busy)
				resolve_reference(mem_address, time_stamp);
		end
	end
endmodule
`default_nettype wire

// ----- dv/tb_l1_victim_l2_cache_lookup.sv -----
// ----------------------------------------------------------------------------
// tb_l1_victim_l2_cache_lookup
// Drives directed and random memory references through the cache lookup over
// several latency settings and sender idle rates; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_l1_victim_l2_cache_lookup;
	import lvc_pkg::*;

	localparam int STALL_LIMIT = 50000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0, is_store = 1'b0;
	logic [31:0] mem_address = '0, time_stamp = '0;
	logic        busy, done;
	level_t      hit_level;
	lat_t        access_latency;
	int          fail_count, pending_count;
	int          idle_pct;
	int          stall_cycles = 0;
	logic [31:0] ts_now;
	logic [L1_TW-1:0] tag_pool [8];
	logic [L1_IW-1:0] set_pool [4];

	always #5 clk = ~clk;

	l1_victim_l2_cache_lookup dut (.*);

	l1_victim_l2_cache_lookup_checker u_checker (.*);

	// Give up after a long stretch with nothing accepted
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_l1_victim_l2_cache_lookup failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Hold a request until taken, then maybe drop start for a random gap
	task automatic send_request(input logic st, input logic [31:0] addr,
			input logic [31:0] ts);
		start <= 1'b1;
		is_store <= st;
		mem_address <= addr;
		time_stamp <= ts;
		do @(posedge clk); while (busy);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Drain results, then let the block settle before touching registers
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d, input logic [31:0] e);
		write_reg(REG_L1, a);
		write_reg(REG_VC, b);
		write_reg(REG_L2, c);
		write_reg(REG_XFER, d);
		write_reg(REG_MEM, e);
	endtask

	// Mostly conflicting addresses over a few sets, some fully random
	function automatic logic [31:0] pick_address();
		if ($urandom_range(0, 99) < 10)
			return $urandom;
		return {tag_pool[$urandom_range(0, 7)], set_pool[$urandom_range(0, 3)],
			4'($urandom)};
	endfunction

	task automatic random_phase(input int count, input int pct);
		idle_pct = pct;
		ts_now = $urandom;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 5)
				ts_now = $urandom;
			else
				ts_now = ts_now + $urandom_range(0, 3);
			send_request(1'($urandom), pick_address(), ts_now);
		end
		drain();
	endtask

	initial begin
		logic [31:0] base;
		idle_pct = 0;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int k = 2; k < 8; k++) tag_pool[k] = L1_TW'($urandom);
		set_pool[0] = '0;
		set_pool[1] = '1;
		set_pool[2] = L1_IW'($urandom);
		set_pool[3] = set_pool[2] ^ L1_IW'(16);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, repeat hits, eviction chain into victim and L2
		send_request(1'b0, 32'h0000_0000, 32'h0);
		send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(1'b0, 32'h0000_0004, 32'h1);
		send_request(1'b1, 32'hFFFF_FFF0, 32'h2);
		base = 32'h0000_0120;
		for (int k = 1; k <= 5; k++)
			send_request(1'b0, base + (k << 11), 32'h100 + k);
		send_request(1'b0, base + (3 << 11), 32'h200);
		send_request(1'b0, base + (1 << 11), 32'h201);
		send_request(1'b0, base + (2 << 11), 32'h202);
		send_request(1'b1, base + (5 << 11), 32'h202);
		send_request(1'b0, base + (6 << 11), 32'h203);
		send_request(1'b0, base + (7 << 11), 32'h203);
		send_request(1'b0, base + (8 << 11), 32'h204);
		send_request(1'b0, base + (4 << 11), 32'h205);
		send_request(1'b0, 32'h8000_0120, 32'h8000_0000);
		send_request(1'b0, 32'h0002_0120, 32'h7FFF_FFFF);
		drain();

		// Random phases across latency settings and idle rates
		write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		random_phase(400, 0);
		write_all(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
		random_phase(400, 48);
		write_all($urandom, $urandom, $urandom, $urandom, $urandom);
		write_reg(3'd5, $urandom);
		random_phase(400, 0);
		write_all($urandom, $urandom, $urandom, $urandom, $urandom);
		random_phase(430, 26);

		if (fail_count == 0 && pending_count == 0) begin
			$display("tb_l1_victim_l2_cache_lookup passed");
		end else begin
			$display("tb_l1_victim_l2_cache_lookup failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lvc_pkg.sv
hw/rtl/l1_victim_l2_cache_lookup.sv
dv/l1_victim_l2_cache_lookup_checker.sv
dv/tb_l1_victim_l2_cache_lookup.sv
